/* rtl/core/shuttle_wobble_pulse_sequencer_core_defines.svh */
// ----------------------------------------------------------------------------
// Shuttle wobble pulse sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk with active-low reset.
// ----------------------------------------------------------------------------
`ifndef SHUTTLE_WOBBLE_PULSE_SEQUENCER_CORE_DEFINES_SVH
`define SHUTTLE_WOBBLE_PULSE_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SWPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swps: same-cycle check failed");

// Next-cycle implication.
`define SWPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swps: next-cycle check failed");

`endif

/* rtl/core/swps_pkg.sv */
// ----------------------------------------------------------------------------
// swps_pkg
// Types and codes shared by the shuttle wobble pulse sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swps_pkg;

    localparam int POS_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_REPORT = 2'd1,
        MODE_START  = 2'd2,
        MODE_STOP   = 2'd3
    } mode_t;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_HIGH_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] CFG_LOW_THRESHOLD  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_WOBBLE_LEG     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_PULSE_TICKS    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_DRIVE_ENABLE   = 3'd4;

    // Drive level codes, 2-bit two's complement
    localparam logic signed [1:0] LEVEL_OFF     = 2'sb00;
    localparam logic signed [1:0] LEVEL_FORWARD = 2'sb01;
    localparam logic signed [1:0] LEVEL_REVERSE = 2'sb11;

    typedef struct packed {
        mode_t                   mode;
        logic signed [POS_W-1:0] position;
    } item_t;

    typedef struct packed {
        logic signed [1:0] drive_level;
        logic              pulse_active;
    } result_t;

    typedef struct packed {
        logic signed [POS_W-1:0] high_threshold;
        logic signed [POS_W-1:0] low_threshold;
        logic [CFG_W-1:0]        wobble_leg_ticks;
        logic [CFG_W-1:0]        pulse_ticks;
        logic                    drive_enable;
    } cfg_t;

endpackage

/* rtl/core/shuttle_wobble_pulse_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Shuttle wobble pulse sequencer core
// Takes one item per cycle while not stalled (poll tick, position report,
// start, stop) and returns one drive result per item. Each accepted item
// updates the sequencer state and its result lands in the output register
// on the same edge; the sustained rate is one item per cycle while the output
// is not stalled, limited by the single next-state pass through swps_seq. The
// input is stalled only while the output register holds a result that the
// consumer is stalling. Configuration writes are always ready and must be
// made while the block is idle. Drive levels are -1, 0 or +1 in 2-bit
// two's complement; a disabled drive still sequences and reports pulses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shuttle_wobble_pulse_sequencer_core
    import swps_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    // item channel
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    // result channel
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    // configuration write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg;
    result_t step_result;
    logic    item_xfer;

    // Input moves whenever the output slot is free or drains this cycle
    assign item_stall = result_valid_reg && result_stall;
    assign item_xfer  = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    swps_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (item_xfer),
        .item   (item),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_threshold   <= 16'sd2560;
            cfg_reg.low_threshold    <= 16'sd0;
            cfg_reg.wobble_leg_ticks <= 16'd25;
            cfg_reg.pulse_ticks      <= 16'd50;
            cfg_reg.drive_enable     <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HIGH_THRESHOLD: cfg_reg.high_threshold   <= cfg_data;
                CFG_LOW_THRESHOLD:  cfg_reg.low_threshold    <= cfg_data;
                CFG_WOBBLE_LEG:     cfg_reg.wobble_leg_ticks <= cfg_data;
                CFG_PULSE_TICKS:    cfg_reg.pulse_ticks      <= cfg_data;
                CFG_DRIVE_ENABLE:   cfg_reg.drive_enable     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Output register: load on every item transfer, clear once taken
    always_comb
    begin
        priority if (item_xfer)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/core/swps_seq.sv */
// ----------------------------------------------------------------------------
// swps_seq
// Sequencer state and its combinational next-state logic for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swps_seq
    import swps_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic                    is_running_reg,       is_running_next;
    logic                    wobble_forward_reg,   wobble_forward_next;
    logic [COUNT_WIDTH-1:0]  wobble_count_reg,     wobble_count_next;
    logic [COUNT_WIDTH-1:0]  pulse_left_reg,       pulse_left_next;
    logic                    pulse_reverse_reg,    pulse_reverse_next;
    logic signed [POS_W-1:0] latest_position_reg,  latest_position_next;
    logic                    have_latest_reg,      have_latest_next;
    logic signed [POS_W-1:0] checked_position_reg, checked_position_next;
    logic                    checked_valid_reg,    checked_valid_next;

    logic [COUNT_WIDTH-1:0]  leg_len;
    logic [COUNT_WIDTH-1:0]  pulse_len;
    logic [COUNT_WIDTH-1:0]  pulse_dec;
    logic [COUNT_WIDTH-1:0]  count_inc;
    logic                    cross_up;
    logic                    cross_down;
    logic                    pulse_now;

    assign leg_len   = COUNT_WIDTH'(cfg.wobble_leg_ticks);
    assign pulse_len = (COUNT_WIDTH'(cfg.pulse_ticks) == '0) ? COUNT_WIDTH'(1)
                                                             : COUNT_WIDTH'(cfg.pulse_ticks);
    assign pulse_dec = pulse_left_reg - COUNT_WIDTH'(1);
    assign count_inc = wobble_count_reg + COUNT_WIDTH'(1);

    // Crossing test against the last checked position; up has priority
    assign cross_up   = have_latest_reg && checked_valid_reg
                     && (checked_position_reg < cfg.high_threshold)
                     && (latest_position_reg >= cfg.high_threshold);
    assign cross_down = have_latest_reg && checked_valid_reg && !cross_up
                     && (checked_position_reg > cfg.low_threshold)
                     && (latest_position_reg <= cfg.low_threshold);

    always_comb
    begin
        is_running_next       = is_running_reg;
        wobble_forward_next   = wobble_forward_reg;
        wobble_count_next     = wobble_count_reg;
        pulse_left_next       = pulse_left_reg;
        pulse_reverse_next    = pulse_reverse_reg;
        latest_position_next  = latest_position_reg;
        have_latest_next      = have_latest_reg;
        checked_position_next = checked_position_reg;
        checked_valid_next    = checked_valid_reg;
        pulse_now             = 1'b0;

        unique case (item.mode)
            MODE_TICK:
            begin
                if (is_running_reg)
                begin
                    if (pulse_left_reg != '0 && pulse_dec != '0)
                    begin
                        pulse_left_next = pulse_dec;
                    end
                    else
                    begin
                        // Crossing check, also on the tick that ends a pulse
                        if (have_latest_reg)
                        begin
                            checked_position_next = latest_position_reg;
                            checked_valid_next    = 1'b1;
                        end
                        pulse_now = cross_up || cross_down;
                        if (pulse_now)
                        begin
                            pulse_left_next    = pulse_len;
                            pulse_reverse_next = cross_down;
                        end
                        else
                        begin
                            pulse_left_next = '0;
                        end

                        if (pulse_left_reg != '0)
                        begin
                            wobble_forward_next = 1'b1;
                            wobble_count_next   = '0;
                        end
                        else if (!pulse_now)
                        begin
                            if (count_inc >= leg_len)
                            begin
                                wobble_forward_next = !wobble_forward_reg;
                                wobble_count_next   = '0;
                            end
                            else
                            begin
                                wobble_count_next = count_inc;
                            end
                        end
                    end
                end
            end
            MODE_REPORT:
            begin
                latest_position_next = item.position;
                have_latest_next     = 1'b1;
            end
            MODE_START:
            begin
                if (!is_running_reg)
                begin
                    is_running_next     = 1'b1;
                    wobble_forward_next = 1'b1;
                    wobble_count_next   = '0;
                    pulse_left_next     = '0;
                end
            end
            MODE_STOP:
            begin
                if (is_running_reg)
                begin
                    is_running_next = 1'b0;
                    pulse_left_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result reflects the state after the item
    always_comb
    begin
        result.pulse_active = is_running_next && (pulse_left_next != '0);
        if (!is_running_next || !cfg.drive_enable)
        begin
            result.drive_level = LEVEL_OFF;
        end
        else if (result.pulse_active)
        begin
            result.drive_level = pulse_reverse_next ? LEVEL_REVERSE : LEVEL_FORWARD;
        end
        else
        begin
            result.drive_level = wobble_forward_next ? LEVEL_FORWARD : LEVEL_REVERSE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_running_reg       <= 1'b0;
            wobble_forward_reg   <= 1'b1;
            wobble_count_reg     <= '0;
            pulse_left_reg       <= '0;
            pulse_reverse_reg    <= 1'b0;
            latest_position_reg  <= '0;
            have_latest_reg      <= 1'b0;
            checked_position_reg <= '0;
            checked_valid_reg    <= 1'b0;
        end
        else if (step)
        begin
            is_running_reg       <= is_running_next;
            wobble_forward_reg   <= wobble_forward_next;
            wobble_count_reg     <= wobble_count_next;
            pulse_left_reg       <= pulse_left_next;
            pulse_reverse_reg    <= pulse_reverse_next;
            latest_position_reg  <= latest_position_next;
            have_latest_reg      <= have_latest_next;
            checked_position_reg <= checked_position_next;
            checked_valid_reg    <= checked_valid_next;
        end
    end

endmodule

/* rtl/core/swps_checker.sv */
// ----------------------------------------------------------------------------
// swps_checker
// Port-level checks on the sequencer core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "shuttle_wobble_pulse_sequencer_core_defines.svh"

module swps_checker
    import swps_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result,
    input logic    cfg_valid,
    input logic    cfg_ready
);

    logic item_xfer;
    logic stop_xfer;
    logic held;
    logic result_off;

    assign item_xfer  = item_valid && !item_stall;
    assign stop_xfer  = item_xfer && (item.mode == MODE_STOP);
    assign held       = result_valid && result_stall;
    assign result_off = (result.drive_level == LEVEL_OFF) && !result.pulse_active;

    // A held result stays put
    `SWPS_ASSERT_NEXT(a_result_hold, clk, rst_n, held, result_valid && $stable(result))
    // Every transferred item shows a result on the next cycle
    `SWPS_ASSERT_NEXT(a_item_to_result, clk, rst_n, item_xfer, result_valid)
    // An empty output slot never stalls the input
    `SWPS_ASSERT_NOW(a_no_idle_stall, clk, rst_n, !result_valid, !item_stall)
    // Stop leaves the drive off with no pulse
    `SWPS_ASSERT_NEXT(a_stop_off, clk, rst_n, stop_xfer, result_off)
    // Register writes are never held off
    `SWPS_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind shuttle_wobble_pulse_sequencer_core swps_checker u_swps_checker (.*);

/* test/tb_shuttle_wobble_pulse_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Shuttle wobble pulse sequencer core testbench
// Drives ticks, position reports, start and stop through the item channel,
// models the wobble and end-pulse sequencing in parallel and checks every
// drive result in order. A short scripted run covers the corner cases, then
// several register settings are exercised with random traffic and idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_shuttle_wobble_pulse_sequencer_core;

    import swps_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 96;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int IDLE_PCT        = 31;

    localparam logic signed [POS_W-1:0] POS_TOP    = 16'sh7FFF;
    localparam logic signed [POS_W-1:0] POS_BOTTOM = 16'sh8000;

    typedef enum bit { ROW_ITEM, ROW_REG } row_kind_t;

    // One line of the scripted run: either a register write or an item,
    // optionally with its drive result typed in.
    typedef struct packed {
        row_kind_t        kind;
        logic [IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0] reg_val;
        item_t            stim;
        bit               typed;
        result_t          want;
    } script_row_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    item_t            item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index    = CFG_HIGH_THRESHOLD;
    logic [CFG_W-1:0] cfg_data     = '0;

    // typed-in expectation that travels alongside a scripted item
    bit               fixed_want_en = 1'b0;
    result_t          fixed_want    = '0;

    // no idling on either side while set
    bit               quiet = 1'b0;

    shuttle_wobble_pulse_sequencer_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Sequencer shadow: registers and state, at reset values
    // ------------------------------------------------------------------------
    logic signed [POS_W-1:0] hi_thr    = 16'sd2560;
    logic signed [POS_W-1:0] lo_thr    = 16'sd0;
    logic [CFG_W-1:0]        leg_len   = 16'd25;
    logic [CFG_W-1:0]        pulse_len = 16'd50;
    logic                    drv_en    = 1'b1;

    logic                    running    = 1'b0;
    logic                    wob_fwd    = 1'b1;
    logic [15:0]             wob_cnt    = '0;
    logic [15:0]             pulse_left = '0;
    logic                    pulse_rev  = 1'b0;
    logic signed [POS_W-1:0] last_pos   = '0;
    logic                    have_pos   = 1'b0;
    logic signed [POS_W-1:0] seen_pos   = '0;
    logic                    seen_valid = 1'b0;

    result_t expected_drive [$];

    int cycle_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int pulses_up       = 0;
    int pulses_down     = 0;
    int reg_writes      = 0;
    int errors          = 0;

    // Crossing check against the last checked position; a crossing opens an
    // end pulse. Upward through the high end wins over downward through the low.
    function automatic void open_pulse_if_crossed();
        int heading;
        heading = 0;
        if (have_pos)
        begin
            if (seen_valid)
            begin
                if (seen_pos < hi_thr && last_pos >= hi_thr)
                    heading = 1;
                else if (seen_pos > lo_thr && last_pos <= lo_thr)
                    heading = -1;
            end
            seen_pos   = last_pos;
            seen_valid = 1'b1;
        end
        if (heading != 0)
        begin
            pulse_left = (pulse_len == '0) ? 16'd1 : pulse_len;
            pulse_rev  = (heading < 0);
            if (pulse_rev)
                pulses_down++;
            else
                pulses_up++;
        end
    endfunction

    // Applies one item to the shadow state and returns the drive after it.
    function automatic result_t advance_sequencer(item_t it);
        result_t          r;
        logic             active;
        logic signed [1:0] lvl;
        case (it.mode)
            MODE_TICK:
            begin
                if (running && pulse_left != '0)
                begin
                    pulse_left = pulse_left - 16'd1;
                    if (pulse_left == '0)
                    begin
                        // pulse over: wobble restarts forward, same tick checks again
                        wob_fwd = 1'b1;
                        wob_cnt = '0;
                        open_pulse_if_crossed();
                    end
                end
                else if (running)
                begin
                    open_pulse_if_crossed();
                    if (pulse_left == '0)
                    begin
                        wob_cnt = wob_cnt + 16'd1;
                        if (wob_cnt >= leg_len)
                        begin
                            wob_fwd = !wob_fwd;
                            wob_cnt = '0;
                        end
                    end
                end
            end
            MODE_REPORT:
            begin
                last_pos = it.position;
                have_pos = 1'b1;
            end
            MODE_START:
            begin
                if (!running)
                begin
                    running    = 1'b1;
                    wob_fwd    = 1'b1;
                    wob_cnt    = '0;
                    pulse_left = '0;
                end
            end
            MODE_STOP:
            begin
                running    = 1'b0;
                pulse_left = '0;
            end
            default:
            begin
            end
        endcase

        active = running && (pulse_left != '0);
        if (!running || !drv_en)
            lvl = LEVEL_OFF;
        else if (active)
            lvl = pulse_rev ? LEVEL_REVERSE : LEVEL_FORWARD;
        else
            lvl = wob_fwd ? LEVEL_FORWARD : LEVEL_REVERSE;
        r.drive_level  = lvl;
        r.pulse_active = active;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and the stalling consumer
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Observer: register writes update the shadow, accepted items queue their
    // predicted drive, accepted results are checked against the oldest one.
    // Everything is sampled at the edge, before that edge's updates land.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : observe
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                case (cfg_index)
                    CFG_HIGH_THRESHOLD: hi_thr    = cfg_data;
                    CFG_LOW_THRESHOLD:  lo_thr    = cfg_data;
                    CFG_WOBBLE_LEG:     leg_len   = cfg_data;
                    CFG_PULSE_TICKS:    pulse_len = cfg_data;
                    CFG_DRIVE_ENABLE:   drv_en    = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            if (item_valid && !item_stall)
            begin
                want = advance_sequencer(item);
                if (fixed_want_en)
                    want = fixed_want;
                expected_drive.push_back(want);
                items_sent++;
            end

            if (result_valid && !result_stall)
            begin
                got = result;
                if (expected_drive.size() == 0)
                begin
                    $error("result transfer with nothing expected: drive_level %0d pulse_active %0d",
                           got.drive_level, got.pulse_active);
                    errors++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    results_checked++;
                    if (got.drive_level !== want.drive_level)
                    begin
                        $error("drive_level mismatch: expected %0d, got %0d",
                               want.drive_level, got.drive_level);
                        errors++;
                    end
                    if (got.pulse_active !== want.pulse_active)
                    begin
                        $error("pulse_active mismatch: expected %0d, got %0d",
                               want.pulse_active, got.pulse_active);
                        errors++;
                    end
                end
            end
        end
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Drops valid and waits until every queued drive result has come back.
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_drive.size() != 0);
    endtask

    // One register write; the block is drained first unless this write
    // directly follows another one.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        if (!cfg_valid)
        begin
            hold_until_drained();
            repeat (2) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // One item transfer, with random idle cycles ahead of it. Returns at the
    // edge that accepted it, with valid still high.
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        cfg_valid <= 1'b0;
        while (!quiet && ($urandom_range(99) < IDLE_PCT))
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        item          <= it;
        fixed_want_en <= typed;
        fixed_want    <= want;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // Report positions cluster around the thresholds so crossings are common.
    function automatic logic signed [POS_W-1:0] pick_position();
        logic signed [POS_W-1:0] off;
        off = POS_W'($urandom_range(8));
        off = off - 16'sd4;
        case ($urandom_range(9))
            0:       return POS_TOP;
            1:       return POS_BOTTOM;
            2, 3:    return POS_W'($urandom);
            4, 5, 6: return hi_thr + off;
            default: return lo_thr + off;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Scripted run, from reset values (high 2560, low 0, leg 25, pulse 50)
    // ------------------------------------------------------------------------
    script_row_t script [28] = '{
        // tick and stop while stopped do nothing
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b1, '{LEVEL_OFF,     1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_STOP,   16'sd0},     1'b1, '{LEVEL_OFF,     1'b0}},
        // start, then start again while running
        '{ROW_ITEM, '0, '0, '{MODE_START,  16'sd0},     1'b1, '{LEVEL_FORWARD, 1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_START,  16'sd0},     1'b1, '{LEVEL_FORWARD, 1'b0}},
        // tick with no report yet
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b1, '{LEVEL_FORWARD, 1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_REPORT, POS_BOTTOM}, 1'b1, '{LEVEL_FORWARD, 1'b0}},
        // first check only takes the baseline
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b1, '{LEVEL_FORWARD, 1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_REPORT, POS_TOP},    1'b1, '{LEVEL_FORWARD, 1'b0}},
        // upward crossing of the high end
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b1, '{LEVEL_FORWARD, 1'b1}},
        '{ROW_ITEM, '0, '0, '{MODE_REPORT, POS_BOTTOM}, 1'b0, '{LEVEL_OFF,     1'b0}},
        // no check while the pulse is held
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b0, '{LEVEL_OFF,     1'b0}},
        // stop drops the pulse, checked position survives the restart
        '{ROW_ITEM, '0, '0, '{MODE_STOP,   16'sd0},     1'b1, '{LEVEL_OFF,     1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_START,  16'sd0},     1'b1, '{LEVEL_FORWARD, 1'b0}},
        // downward crossing of the low end
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b1, '{LEVEL_REVERSE, 1'b1}},
        '{ROW_ITEM, '0, '0, '{MODE_STOP,   16'sd0},     1'b1, '{LEVEL_OFF,     1'b0}},
        // zero pulse length and zero wobble leg
        '{ROW_REG, CFG_PULSE_TICKS, 16'd0, '{MODE_TICK, 16'sd0}, 1'b0, '{LEVEL_OFF, 1'b0}},
        '{ROW_REG, CFG_WOBBLE_LEG,  16'd0, '{MODE_TICK, 16'sd0}, 1'b0, '{LEVEL_OFF, 1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_START,  16'sd0},     1'b1, '{LEVEL_FORWARD, 1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b1, '{LEVEL_REVERSE, 1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b1, '{LEVEL_FORWARD, 1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_REPORT, POS_TOP},    1'b1, '{LEVEL_FORWARD, 1'b0}},
        // a zero-length pulse lasts one tick
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b1, '{LEVEL_FORWARD, 1'b1}},
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b1, '{LEVEL_FORWARD, 1'b0}},
        // drive disabled: level stays off, pulse still reported
        '{ROW_REG, CFG_DRIVE_ENABLE, 16'd0, '{MODE_TICK, 16'sd0}, 1'b0, '{LEVEL_OFF, 1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_REPORT, POS_BOTTOM}, 1'b1, '{LEVEL_OFF,     1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b1, '{LEVEL_OFF,     1'b1}},
        '{ROW_ITEM, '0, '0, '{MODE_TICK,   16'sd0},     1'b1, '{LEVEL_OFF,     1'b0}},
        '{ROW_ITEM, '0, '0, '{MODE_STOP,   16'sd0},     1'b1, '{LEVEL_OFF,     1'b0}}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : run
        item_t                   it;
        result_t                 none;
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] lo;
        logic [CFG_W-1:0]        leg;
        logic [CFG_W-1:0]        plen;
        logic                    en;
        logic                    gen_running;
        int                      roll;
        int                      count;

        none = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scripted corner cases
        for (int i = 0; i < $size(script); i++)
        begin
            if (script[i].kind == ROW_REG)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                send_item(script[i].stim, script[i].typed, script[i].want);
        end

        // random phases, each under its own register setting
        gen_running = 1'b0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    hi = 16'sd256; lo = -16'sd256; leg = 16'd3; plen = 16'd4; en = 1'b1;
                end
                1:
                begin
                    // extremes: widest hallway, longest legs and pulses
                    hi = POS_TOP; lo = POS_BOTTOM; leg = 16'hFFFF; plen = 16'hFFFF; en = 1'b1;
                end
                2:
                begin
                    // inverted extremes: no crossing can ever be found
                    hi = POS_BOTTOM; lo = POS_TOP; leg = 16'd1; plen = 16'd1; en = 1'b0;
                end
                default:
                begin
                    hi = POS_W'($urandom_range(1024));
                    hi = hi - 16'sd512;
                    lo = POS_W'($urandom_range(600));
                    lo = hi - lo + 16'sd100;
                    if ($urandom_range(4) == 0)
                        hi = POS_W'($urandom);
                    leg  = CFG_W'($urandom_range(6));
                    plen = CFG_W'($urandom_range(6));
                    en   = ($urandom_range(3) != 0);
                end
            endcase
            write_reg(CFG_HIGH_THRESHOLD, hi);
            write_reg(CFG_LOW_THRESHOLD,  lo);
            write_reg(CFG_WOBBLE_LEG,     leg);
            write_reg(CFG_PULSE_TICKS,    plen);
            write_reg(CFG_DRIVE_ENABLE,   {{(CFG_W-1){1'b0}}, en});

            // one phase runs back to back with no idling on either side
            quiet = (p == 3);

            count = 0;
            while (count < ITEMS_PER_PHASE)
            begin
                // mostly started sequences of ticks and reports, some noise
                roll = $urandom_range(99);
                if (!gen_running)
                    it.mode = (roll < 65) ? MODE_START :
                              (roll < 80) ? MODE_REPORT :
                              (roll < 92) ? MODE_TICK : MODE_STOP;
                else
                    it.mode = (roll < 48) ? MODE_TICK :
                              (roll < 88) ? MODE_REPORT :
                              (roll < 94) ? MODE_STOP : MODE_START;
                it.position = (it.mode == MODE_REPORT) ? pick_position()
                                                       : POS_W'($urandom);

                // items that change nothing are not counted
                if (!((it.mode == MODE_TICK && !gen_running) ||
                      (it.mode == MODE_START && gen_running) ||
                      (it.mode == MODE_STOP && !gen_running)))
                    count++;
                if (it.mode == MODE_START)
                    gen_running = 1'b1;
                else if (it.mode == MODE_STOP)
                    gen_running = 1'b0;

                send_item(it, 1'b0, none);

                // halfway through the phase's counted items, let the pipeline run dry
                if (count == ITEMS_PER_PHASE / 2)
                    hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (4) @(posedge clk);
        if (expected_drive.size() != 0)
        begin
            $error("%0d drive results never arrived", expected_drive.size());
            errors++;
        end

        $display("covered %0d items, %0d results checked, %0d register writes, %0d phases",
                 items_sent, results_checked, reg_writes, NUM_PHASES);
        $display("end pulses opened: %0d upward, %0d downward", pulses_up, pulses_down);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/swps_pkg.sv
rtl/core/swps_seq.sv
rtl/core/shuttle_wobble_pulse_sequencer_core.sv
rtl/core/swps_checker.sv
test/tb_shuttle_wobble_pulse_sequencer_core.sv
